/* rtl/spm_pkg.sv */
package spm_pkg;

	// Q16 level format: 65536 stands for full scale
	localparam int LEVEL_W = 17;
	localparam logic [LEVEL_W-1:0] ONE_Q16 = 17'h10000;
	// one segment step (1/32), used for hold capture rounding and drop threshold
	localparam logic [LEVEL_W-1:0] STEP_Q16 = 17'd2048;
	localparam int STEP_SHIFT = 11;
	// half an LSB of the segment index, for marker rounding
	localparam int HALF_Q16 = 32767;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 17;
	localparam int CNT_W = 2;

	localparam logic [CNT_W-1:0] CHANNEL_COUNT_RST = 2'd2;
	localparam logic [LEVEL_W-1:0] PEAK_DECAY_RST = 17'd2621;
	localparam logic [LEVEL_W-1:0] SPEED_STEP_RST = 17'd524;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_CHANNEL_COUNT = 2'd0,
		REG_PEAK_DECAY    = 2'd1,
		REG_SPEED_STEP    = 2'd2
	} reg_idx_t;

	// operand selection of the shared multiplier
	typedef enum logic [1:0] {
		MUL_SPEED,   // speed * speed
		MUL_SQUARE,  // product * product
		MUL_BY_S4    // product * speed^4
	} mul_op_t;

	typedef struct packed {
		logic    level_update;
		logic    tick_start;
		logic    mul_en;
		mul_op_t mul_op;
		logic    save_s4;
		logic    age;
		logic    ch;
		logic    mask_prep;
		logic    load_out;
	} dp_cmd_t;

endpackage

/* rtl/stereo_peak_meter_with_hold.sv */
// Stereo LED-bar peak meter with a falling peak-hold marker, levels in unsigned
// Q16 (65536 = full scale, larger inputs saturate). A level transaction
// (tuser = 0) only raises the per-channel peaks. A tick transaction (tuser = 1)
// ages both channels and produces one result: the two segment masks and a
// redraw flag. A tick occupies the block: one shared 17x17 multiplier forms
// speed^12 in four registered steps per channel, and the steps of each channel
// are followed by one aging step for it; then one step stages the bar limits
// and one loads the output register. The output register holds a result until
// it is taken; level transactions are accepted meanwhile, and a following tick
// waits only at its final load step. Configuration must be written through
// cfg_we/cfg_addr/cfg_wdata while the block is idle; the block does not enforce this.
module stereo_peak_meter_with_hold #(
	parameter int SEGMENTS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [39:0]                     s_tdata,  // left_level[16:0], right_level[33:17]
	input  logic [0:0]                      s_tuser,  // operation
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [63:0]                     m_tdata,  // left_segments[31:0], right_segments[63:32]
	output logic [0:0]                      m_tuser,  // redraw
	input  logic                            cfg_we,
	input  logic [spm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [spm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	spm_pkg::dp_cmd_t cmd;
	logic [31:0]      left_segments;
	logic [31:0]      right_segments;
	logic             redraw;

	spm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.operation (s_tuser[0]),
		.s_tready  (s_tready),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.cmd       (cmd)
	);

	spm_dpath #(
		.SEGMENTS (SEGMENTS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.left_level     (s_tdata[16:0]),
		.right_level    (s_tdata[33:17]),
		.left_segments  (left_segments),
		.right_segments (right_segments),
		.redraw         (redraw)
	);

	assign m_tdata = {right_segments, left_segments};
	assign m_tuser = redraw;

endmodule

/* rtl/spm_ctrl.sv */
module spm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              operation,
	output logic              s_tready,
	input  logic              m_tready,
	output logic              m_tvalid,
	output spm_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ2,
		ST_SQ4,
		ST_SQ8,
		ST_SQ12,
		ST_AGE,
		ST_MASK,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   ch_q;
	logic   m_tvalid_q;
	logic   accept;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign out_free = ~m_tvalid_q | m_tready;
	assign m_tvalid = m_tvalid_q;

	// sequence a tick: four multiplies and an aging step per channel, then masks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ch_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// raise the result flag on a load, drop it once taken
			if (state_q == ST_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && operation) begin
						ch_q    <= 1'b0;
						state_q <= ST_SQ2;
					end
				end
				ST_SQ2:  state_q <= ST_SQ4;
				ST_SQ4:  state_q <= ST_SQ8;
				ST_SQ8:  state_q <= ST_SQ12;
				ST_SQ12: state_q <= ST_AGE;
				ST_AGE: begin
					if (!ch_q) begin
						ch_q    <= 1'b1;
						state_q <= ST_SQ2;
					end else begin
						state_q <= ST_MASK;
					end
				end
				ST_MASK: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// decode datapath commands
	always_comb begin
		cmd              = '0;
		cmd.mul_op       = spm_pkg::MUL_SPEED;
		cmd.ch           = ch_q;
		cmd.level_update = accept & ~operation;
		cmd.tick_start   = accept & operation;
		case (state_q)
			ST_SQ2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = spm_pkg::MUL_SPEED;
			end
			ST_SQ4: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_op  = spm_pkg::MUL_SQUARE;
				cmd.save_s4 = 1'b1;
			end
			ST_SQ8: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = spm_pkg::MUL_SQUARE;
			end
			ST_SQ12: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = spm_pkg::MUL_BY_S4;
			end
			ST_AGE:  cmd.age = 1'b1;
			ST_MASK: cmd.mask_prep = 1'b1;
			ST_EMIT: cmd.load_out = out_free;
			default: ;
		endcase
	end

endmodule

/* rtl/spm_dpath.sv */
module spm_dpath #(
	parameter int SEGMENTS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  spm_pkg::dp_cmd_t                    cmd,
	input  logic                                cfg_we,
	input  logic [spm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [spm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic [spm_pkg::LEVEL_W-1:0]         left_level,
	input  logic [spm_pkg::LEVEL_W-1:0]         right_level,
	output logic [31:0]                         left_segments,
	output logic [31:0]                         right_segments,
	output logic                                redraw
);

	localparam int LW    = spm_pkg::LEVEL_W;
	localparam int LIM_W = LW + $clog2(SEGMENTS + 1);
	localparam int IDX_W = LIM_W - 16;
	localparam int CMP_W = (IDX_W + 1 > 6) ? IDX_W + 1 : 6;

	// configuration
	logic [spm_pkg::CNT_W-1:0] cnt_q;
	logic [LW-1:0]             decay_q;
	logic [LW-1:0]             step_q;

	// meter state
	logic [LW-1:0] peak_q [2];
	logic [LW-1:0] hold_q [2];
	logic          valid_q [2];
	logic [LW-1:0] speed_q [2];
	logic [LW-1:0] last_peak_q [2];
	logic [LW:0]   last_hold_q [2];
	logic          changed_q;

	// multiplier and mask staging
	logic [LW-1:0]  p_q;
	logic [LW-1:0]  s4_q;
	logic [IDX_W-1:0] lim_hi_q [2];
	logic [IDX_W:0]   mark_q [2];
	logic [31:0]      out_left_q;
	logic [31:0]      out_right_q;
	logic             redraw_q;

	logic [LW-1:0]   lv [2];
	logic [LW-1:0]   mul_a;
	logic [LW-1:0]   mul_b;
	logic [2*LW-1:0] prod;

	logic [LW-1:0] sel_peak;
	logic [LW-1:0] h0;
	logic [LW-1:0] h1;
	logic [LW-1:0] h2;
	logic [LW:0]   spd_sum;
	logic [LW-1:0] spd_sat;
	logic [LW-1:0] spd_new;
	logic [LW:0]   rnd_sum;
	logic [LW-1:0] rounded;
	logic          recap;
	logic          keep;
	logic [LW-1:0] hold_new;
	logic [LW-1:0] peak_new;
	logic [LW:0]   code_new;
	logic          differs;

	logic [LIM_W-1:0] lim_full [2];
	logic [LIM_W-1:0] dpos [2];
	logic [LIM_W:0]   dmark [2];
	logic [31:0]      mask [2];

	// saturate incoming levels
	assign lv[0] = (left_level > spm_pkg::ONE_Q16) ? spm_pkg::ONE_Q16 : left_level;
	assign lv[1] = (right_level > spm_pkg::ONE_Q16) ? spm_pkg::ONE_Q16 : right_level;

	// shared multiplier operands
	always_comb begin
		case (cmd.mul_op)
			spm_pkg::MUL_SPEED: begin
				mul_a = speed_q[cmd.ch];
				mul_b = speed_q[cmd.ch];
			end
			spm_pkg::MUL_SQUARE: begin
				mul_a = p_q;
				mul_b = p_q;
			end
			spm_pkg::MUL_BY_S4: begin
				mul_a = p_q;
				mul_b = s4_q;
			end
			default: begin
				mul_a = p_q;
				mul_b = p_q;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	// age one channel: drop by speed^12, recapture on a higher peak, decay the peak
	always_comb begin
		sel_peak = peak_q[cmd.ch];
		h0       = valid_q[cmd.ch] ? hold_q[cmd.ch] : '0;
		h1       = (h0 > p_q) ? h0 - p_q : '0;
		spd_sum  = {1'b0, speed_q[cmd.ch]} + {1'b0, step_q};
		spd_sat  = (spd_sum > {1'b0, spm_pkg::ONE_Q16}) ? spm_pkg::ONE_Q16 : spd_sum[LW-1:0];
		rnd_sum  = {1'b0, sel_peak} + (LW+1)'(spm_pkg::STEP_Q16 - 1'b1);
		rounded  = {rnd_sum[LW-1:spm_pkg::STEP_SHIFT], {spm_pkg::STEP_SHIFT{1'b0}}};
		recap    = (h1 < sel_peak);
		h2       = recap ? rounded : h1;
		spd_new  = recap ? '0 : spd_sat;
		keep     = (h2 > spm_pkg::STEP_Q16);
		hold_new = keep ? h2 : '0;
		peak_new = (sel_peak > decay_q) ? sel_peak - decay_q : '0;
		code_new = {keep, hold_new};
		differs  = (peak_new != last_peak_q[cmd.ch]) || (code_new != last_hold_q[cmd.ch]);
	end

	// configuration writes and meter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= spm_pkg::CHANNEL_COUNT_RST;
			decay_q   <= spm_pkg::PEAK_DECAY_RST;
			step_q    <= spm_pkg::SPEED_STEP_RST;
			changed_q <= 1'b0;
			for (int c = 0; c < 2; c++) begin
				peak_q[c]      <= '0;
				hold_q[c]      <= '0;
				valid_q[c]     <= 1'b0;
				speed_q[c]     <= '0;
				last_peak_q[c] <= '0;
				last_hold_q[c] <= {1'b1, {LW{1'b0}}};
			end
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					spm_pkg::REG_CHANNEL_COUNT: cnt_q <= cfg_wdata[spm_pkg::CNT_W-1:0];
					spm_pkg::REG_PEAK_DECAY:    decay_q <= cfg_wdata;
					spm_pkg::REG_SPEED_STEP:    step_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.level_update) begin
				for (int c = 0; c < 2; c++) begin
					if (lv[c] > peak_q[c]) begin
						peak_q[c] <= lv[c];
					end
				end
			end
			if (cmd.tick_start) begin
				changed_q <= 1'b0;
			end
			if (cmd.age) begin
				peak_q[cmd.ch]      <= peak_new;
				hold_q[cmd.ch]      <= hold_new;
				valid_q[cmd.ch]     <= keep;
				speed_q[cmd.ch]     <= spd_new;
				last_peak_q[cmd.ch] <= peak_new;
				last_hold_q[cmd.ch] <= code_new;
				if (differs) begin
					changed_q <= 1'b1;
				end
			end
		end
	end

	// bar limit and marker index per channel
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			lim_full[c] = LIM_W'(peak_q[c]) * LIM_W'(SEGMENTS);
			dpos[c]     = LIM_W'(hold_q[c]) * LIM_W'(SEGMENTS - 1);
			dmark[c]    = (LIM_W+1)'(dpos[c]) + (LIM_W+1)'(spm_pkg::HALF_Q16);
		end
	end

	// light segments up to the bar limit, plus the marker
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			mask[c] = '0;
			for (int i = 0; i < 32; i++) begin
				if (i < SEGMENTS) begin
					mask[c][i] = (CMP_W'(i) <= CMP_W'(lim_hi_q[c]))
						|| (valid_q[c] && (CMP_W'(i) == CMP_W'(mark_q[c])));
				end
			end
		end
	end

	// product, mask staging and result registers
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			p_q <= prod[LW+15:16];
		end
		if (cmd.save_s4) begin
			s4_q <= prod[LW+15:16];
		end
		if (cmd.mask_prep) begin
			for (int c = 0; c < 2; c++) begin
				lim_hi_q[c] <= lim_full[c][LIM_W-1:16];
				mark_q[c]   <= dmark[c][LIM_W:16];
			end
		end
		if (cmd.load_out) begin
			out_left_q  <= (cnt_q != '0) ? mask[0] : '0;
			out_right_q <= cnt_q[1] ? mask[1] : '0;
			redraw_q    <= changed_q;
		end
	end

	assign left_segments  = out_left_q;
	assign right_segments = out_right_q;
	assign redraw         = redraw_q;

endmodule

/* dv/stereo_peak_meter_with_hold_test.sv */
module stereo_peak_meter_with_hold_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic {
		OP_LEVEL = 1'b0,
		OP_TICK  = 1'b1
	} meter_op_t;

	// one display frame as the block should emit it
	typedef struct {
		logic [31:0] left_segs;
		logic [31:0] right_segs;
		logic        redraw;
	} meter_frame_t;

	// Tracks the meter state and queues the frame every tick transaction should produce.
	class meter_scoreboard;
		logic [1:0]  channel_count;
		logic [16:0] peak_decay;
		logic [16:0] speed_step;
		logic [16:0] peak[2];
		logic [16:0] hold[2];
		logic        hold_ok[2];
		logic [16:0] speed[2];
		logic [16:0] prev_peak[2];
		logic [17:0] prev_hold[2];
		meter_frame_t frames_due[$];
		int errors;

		function new();
			channel_count = spm_pkg::CHANNEL_COUNT_RST;
			peak_decay = spm_pkg::PEAK_DECAY_RST;
			speed_step = spm_pkg::SPEED_STEP_RST;
			for (int c = 0; c < 2; c++) begin
				peak[c] = '0;
				hold[c] = '0;
				hold_ok[c] = 1'b0;
				speed[c] = '0;
				prev_peak[c] = '0;
				prev_hold[c] = 18'h20000;
			end
			errors = 0;
		endfunction

		function void write_register(spm_pkg::reg_idx_t idx, logic [16:0] value);
			case (idx)
				spm_pkg::REG_CHANNEL_COUNT: channel_count = value[1:0];
				spm_pkg::REG_PEAK_DECAY:    peak_decay = value;
				spm_pkg::REG_SPEED_STEP:    speed_step = value;
				default: ;
			endcase
		endfunction

		function void note_item(meter_op_t op, logic [16:0] left_lvl, logic [16:0] right_lvl);
			logic [16:0] lvl[2];
			longint unsigned h, s2, s4, s8, s12, sp;
			longint lim, d, pos;
			logic [17:0] code;
			logic [31:0] mask[2];
			logic changed;
			int active;

			lvl[0] = (left_lvl > spm_pkg::ONE_Q16) ? spm_pkg::ONE_Q16 : left_lvl;
			lvl[1] = (right_lvl > spm_pkg::ONE_Q16) ? spm_pkg::ONE_Q16 : right_lvl;
			// level update: keep the running maximum, no frame
			if (op == OP_LEVEL) begin
				for (int c = 0; c < 2; c++)
					if (lvl[c] > peak[c])
						peak[c] = lvl[c];
				return;
			end

			changed = 1'b0;
			for (int c = 0; c < 2; c++) begin
				// drop the hold by speed^12, truncating every product
				h = hold_ok[c] ? hold[c] : 0;
				s2 = (longint'(speed[c]) * speed[c]) >> 16;
				s4 = (s2 * s2) >> 16;
				s8 = (s4 * s4) >> 16;
				s12 = (s8 * s4) >> 16;
				h = (h > s12) ? h - s12 : 0;
				sp = longint'(speed[c]) + speed_step;
				speed[c] = (sp > spm_pkg::ONE_Q16) ? spm_pkg::ONE_Q16 : sp[16:0];
				// recapture at the peak rounded up to the next segment step
				if (h < peak[c]) begin
					h = (longint'(peak[c]) + spm_pkg::STEP_Q16 - 1)
						& ~(longint'(spm_pkg::STEP_Q16) - 1);
					speed[c] = '0;
				end
				if (h <= spm_pkg::STEP_Q16) begin
					hold_ok[c] = 1'b0;
					hold[c] = '0;
				end else begin
					hold_ok[c] = 1'b1;
					hold[c] = h[16:0];
				end
				peak[c] = (peak[c] > peak_decay) ? peak[c] - peak_decay : '0;
				code = hold_ok[c] ? {1'b1, hold[c]} : '0;
				if (peak[c] != prev_peak[c] || code != prev_hold[c])
					changed = 1'b1;
				prev_peak[c] = peak[c];
				prev_hold[c] = code;
			end

			// build the bar plus the rounded marker position
			active = (channel_count > 2) ? 2 : channel_count;
			for (int c = 0; c < 2; c++) begin
				mask[c] = '0;
				lim = longint'(peak[c]) * 32;
				d = longint'(hold[c]) * 31;
				for (int i = 0; i < 32; i++) begin
					pos = longint'(i) * 65536;
					if (pos <= lim || (hold_ok[c] && pos >= d - 32768 && pos < d + 32768))
						mask[c][i] = 1'b1;
				end
				if (c >= active)
					mask[c] = '0;
			end
			frames_due.push_back('{left_segs: mask[0], right_segs: mask[1], redraw: changed});
		endfunction

		function void check_frame(logic [63:0] data, logic redraw);
			meter_frame_t want;
			if (frames_due.size() == 0) begin
				$error("frame with no tick pending: segments %h redraw %b", data, redraw);
				errors++;
				return;
			end
			want = frames_due.pop_front();
			if (data[31:0] !== want.left_segs) begin
				$error("left_segments: expected %h, got %h", want.left_segs, data[31:0]);
				errors++;
			end
			if (data[63:32] !== want.right_segs) begin
				$error("right_segments: expected %h, got %h", want.right_segs, data[63:32]);
				errors++;
			end
			if (redraw !== want.redraw) begin
				$error("redraw: expected %b, got %b", want.redraw, redraw);
				errors++;
			end
		endfunction

		function int pending();
			return frames_due.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [39:0]                    s_tdata;  // left_level[16:0], right_level[33:17]
	logic [0:0]                     s_tuser;  // operation
	logic                           m_tvalid;
	logic                           m_tready;
	logic [63:0]                    m_tdata;  // left_segments[31:0], right_segments[63:32]
	logic [0:0]                     m_tuser;  // redraw
	logic                           cfg_we;
	logic [spm_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [spm_pkg::CFG_DATA_W-1:0] cfg_wdata;

	meter_scoreboard sb;
	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold_cycles;

	stereo_peak_meter_with_hold dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#(10_000_000);
		$display("TEST FAILED");
		$finish;
	end

	// receiver: random backpressure, plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				m_tready <= 1'b0;
				rx_hold_cycles--;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// check every frame transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_frame(m_tdata, m_tuser[0]);
	end

	task automatic send_item(meter_op_t op, logic [16:0] left_lvl, logic [16:0] right_lvl);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'b0, right_lvl, left_lvl};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_item(op, left_lvl, right_lvl);
	endtask

	// stop offering, wait out every frame, then let the pipeline settle
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_register(spm_pkg::reg_idx_t idx, logic [16:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		sb.write_register(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [16:0] random_level();
		case ($urandom_range(7))
			0: return '0;
			1: return spm_pkg::ONE_Q16;
			2: return 17'($urandom_range(65537, 131071));
			3: return 17'($urandom_range(0, 4096));
			4: return 17'($urandom_range(2040, 2056));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	// random mix of levels and ticks, with runs of ticks so holds can fall
	task automatic run_random(int count);
		int tick_run;
		tick_run = 0;
		for (int k = 0; k < count; k++) begin
			if (tick_run == 0 && $urandom_range(99) < 6)
				tick_run = $urandom_range(5, 60);
			if (tick_run > 0) begin
				tick_run--;
				send_item(OP_TICK, 17'($urandom), 17'($urandom));
			end else if ($urandom_range(99) < 55) begin
				send_item(OP_LEVEL, random_level(), random_level());
			end else begin
				send_item(OP_TICK, 17'($urandom), 17'($urandom));
			end
		end
	endtask

	initial begin
		logic [16:0] cfg_count[6] = '{17'd2, 17'd1, 17'd3, 17'd0, 17'd2, 17'd1};
		logic [16:0] cfg_decay[6] = '{17'd2621, 17'd0, 17'd131071, 17'd65536, 17'd1, 17'd300};
		logic [16:0] cfg_step[6] = '{17'd524, 17'd65536, 17'd131071, 17'd8192, 17'd0, 17'd2000};

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_cycles = 0;
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: first-tick redraw, quiet tick, saturation, capture rounding
		send_item(OP_TICK, '0, '0);
		send_item(OP_TICK, '0, '0);
		send_item(OP_LEVEL, 17'd2048, 17'd2049);
		send_item(OP_TICK, '0, '0);
		send_item(OP_LEVEL, 17'd1, 17'd4095);
		send_item(OP_TICK, '0, '0);
		send_item(OP_LEVEL, spm_pkg::ONE_Q16, 17'd65535);
		send_item(OP_TICK, '0, '0);
		send_item(OP_LEVEL, 17'h1FFFF, 17'h10001);
		send_item(OP_TICK, 17'h1FFFF, 17'h1FFFF);
		send_item(OP_LEVEL, '0, '0);
		repeat (9) send_item(OP_TICK, '0, '0);
		send_item(OP_LEVEL, 17'h15555, 17'h0AAAA);
		send_item(OP_TICK, '0, '0);
		drain();

		// random phases, each under its own register setting
		for (int p = 0; p < 6; p++) begin
			write_register(spm_pkg::REG_CHANNEL_COUNT, cfg_count[p]);
			write_register(spm_pkg::REG_PEAK_DECAY, cfg_decay[p]);
			write_register(spm_pkg::REG_SPEED_STEP, cfg_step[p]);
			case (p / 2)
				0: begin
					tx_idle_pct = 34;
					rx_idle_pct = 76;
				end
				1: begin
					tx_idle_pct = 76;
					rx_idle_pct = 34;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			// hold off the receiver long enough to back up the input
			if (p == 4)
				rx_hold_cycles = 400;
			run_random(230);
			drain();
		end

		repeat (20) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d frames never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* stereo_peak_meter_with_hold.f */
rtl/spm_pkg.sv
rtl/spm_ctrl.sv
rtl/spm_dpath.sv
rtl/stereo_peak_meter_with_hold.sv
dv/stereo_peak_meter_with_hold_test.sv
